/* design/dmrm_pkg.sv */
package dmrm_pkg;

	// Field widths
	localparam int POS_W     = 12;
	localparam int SAMPLE_W  = 16;
	localparam int VAL_W     = 15;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	// Reset value of both image size registers
	localparam int IMAGE_SIZE_RST = 1024;

	// Item modes
	localparam logic MODE_MERGE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	// Response sample as it travels the pipeline
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [VAL_W-1:0]    cell_val_t;

endpackage

/* design/downsampled_max_response_map.sv */
// Beats pass stage 1, stage 2 and the output register; one beat/cycle while in_stall is low.
// The map lives in one MAX_MAP_WIDTH*MAX_MAP_HEIGHT synchronous RAM with one write port;
// a merge reads its cell, takes the max and writes it back, forwarding the last write.
// Reset and every configuration write start a clearing sweep that writes zero to each of the
// MAX_MAP_WIDTH*MAX_MAP_HEIGHT cells; in_stall is held high during the sweep.
// Control state and map size registers reset asynchronously on arst_n low.
module downsampled_max_response_map #(
	parameter int DOWNSAMPLE     = 4,
	parameter int MAX_MAP_WIDTH  = 256,
	parameter int MAX_MAP_HEIGHT = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [dmrm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dmrm_pkg::CFG_W-1:0]            cfg_wdata,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [dmrm_pkg::POS_W-1:0]            pos_x,
	input  logic [dmrm_pkg::POS_W-1:0]            pos_y,
	input  logic signed [dmrm_pkg::SAMPLE_W-1:0]  sample,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dmrm_pkg::VAL_W-1:0]            cell_value,
	output logic                                  hit
);

	localparam int QW     = dmrm_pkg::POS_W;
	localparam int EXT_W  = QW + 1;
	localparam int DEPTH  = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW_W   = $clog2(MAX_MAP_WIDTH + 1);
	localparam int MH_W   = $clog2(MAX_MAP_HEIGHT + 1);
	localparam int CMPW_W = (MW_W > QW) ? MW_W : QW;
	localparam int CMPH_W = (MH_W > QW) ? MH_W : QW;
	localparam int PROD_W = QW + MW_W;

	// Division by DOWNSAMPLE as a multiply by a rounded-up reciprocal; exact for 12-bit values
	localparam int SHIFT   = 24;
	localparam int RECIP_W = SHIFT + 1;
	localparam longint RECIP = ((64'd1 << SHIFT) + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	// Map size after reset
	localparam int MW_CEIL = (dmrm_pkg::IMAGE_SIZE_RST + DOWNSAMPLE - 1) / DOWNSAMPLE;
	localparam int MW_RST  = (MW_CEIL < 1) ? 1 :
		((MW_CEIL > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : MW_CEIL);
	localparam int MH_RST  = (MW_CEIL < 1) ? 1 :
		((MW_CEIL > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : MW_CEIL);

	// Quotient of a 12-bit value by DOWNSAMPLE
	function automatic logic [QW-1:0] div_ds(input logic [QW-1:0] v);
		logic [QW+RECIP_W-1:0] prod;
		prod = QW'(v) * RECIP_C;
		return prod[SHIFT +: QW];
	endfunction

	// max(1, min(limit, ceil(pixels / DOWNSAMPLE)))
	function automatic logic [EXT_W-1:0] map_extent(input logic [dmrm_pkg::CFG_W-1:0] pixels,
			input logic [EXT_W-1:0] limit);
		logic [QW-1:0]    sum;
		logic [EXT_W-1:0] cells;
		sum   = QW'(pixels) + QW'(DOWNSAMPLE - 1);
		cells = EXT_W'(div_ds(sum));
		if (cells < EXT_W'(1)) begin
			cells = EXT_W'(1);
		end
		if (cells > limit) begin
			cells = limit;
		end
		return cells;
	endfunction

	logic [MW_W-1:0]   map_w_q;
	logic [MH_W-1:0]   map_h_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              adv;
	logic              in_acc;

	logic                      valid_s1;
	logic                      mode_s1;
	dmrm_pkg::sample_t         sample_s1;
	logic [QW-1:0]             mx_s1;
	logic [QW-1:0]             my_s1;

	logic                      valid_s2;
	logic                      mode_s2;
	dmrm_pkg::sample_t         sample_s2;
	logic                      hit_s2;
	logic [ADDR_W-1:0]         addr_s2;

	logic                      fwd_en_q;
	logic [ADDR_W-1:0]         fwd_addr_q;
	dmrm_pkg::cell_val_t       fwd_data_q;

	logic                      out_valid_q;
	dmrm_pkg::cell_val_t       cell_value_q;
	logic                      hit_q;

	dmrm_pkg::cell_val_t       mem [DEPTH];
	dmrm_pkg::cell_val_t       rd_q;

	logic                      hit_s1;
	logic [PROD_W-1:0]         idx_full_s1;
	logic [ADDR_W-1:0]         idx_s1;
	dmrm_pkg::cell_val_t       old_s2;
	dmrm_pkg::cell_val_t       new_s2;
	logic                      wr_item_s2;
	logic                      mem_we;
	logic [ADDR_W-1:0]         mem_waddr;
	dmrm_pkg::cell_val_t       mem_wdata;

	// Pipeline moves when the output register is free or being taken
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv || clearing_q;
	assign in_acc   = in_valid && !in_stall;

	// Map size registers and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q    <= MW_W'(MW_RST);
			map_h_q    <= MH_W'(MH_RST);
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dmrm_pkg::CFG_IMAGE_WIDTH: begin
					map_w_q <= MW_W'(map_extent(cfg_wdata, EXT_W'(MAX_MAP_WIDTH)));
				end
				dmrm_pkg::CFG_IMAGE_HEIGHT: begin
					map_h_q <= MH_W'(map_extent(cfg_wdata, EXT_W'(MAX_MAP_HEIGHT)));
				end
				default: begin
				end
			endcase
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	// Stage 1: cell column and row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_acc) begin
			mode_s1   <= mode;
			sample_s1 <= sample;
			mx_s1     <= div_ds(pos_x);
			my_s1     <= div_ds(pos_y);
		end
	end

	// Bounds check and linear cell index
	assign hit_s1      = (CMPW_W'(mx_s1) < CMPW_W'(map_w_q)) &&
	                     (CMPH_W'(my_s1) < CMPH_W'(map_h_q));
	assign idx_full_s1 = my_s1 * map_w_q + PROD_W'(mx_s1);
	assign idx_s1      = idx_full_s1[ADDR_W-1:0];

	// Stage 2: RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2   <= mode_s1;
			sample_s2 <= sample_s1;
			hit_s2    <= hit_s1;
			addr_s2   <= idx_s1;
		end
	end

	// Forward the write made at the edge this beat's read was issued
	assign old_s2 = (fwd_en_q && fwd_addr_q == addr_s2) ? fwd_data_q : rd_q;

	// Max merge; a negative sample never wins
	always_comb begin
		new_s2 = old_s2;
		if (mode_s2 == dmrm_pkg::MODE_MERGE && !sample_s2[dmrm_pkg::SAMPLE_W-1] &&
				sample_s2[dmrm_pkg::VAL_W-1:0] > old_s2) begin
			new_s2 = sample_s2[dmrm_pkg::VAL_W-1:0];
		end
	end

	assign wr_item_s2 = adv && valid_s2 && hit_s2 && mode_s2 == dmrm_pkg::MODE_MERGE;

	// RAM write port shared by the sweep and the merge
	assign mem_we    = clearing_q || wr_item_s2;
	assign mem_waddr = clearing_q ? clr_cnt_q : addr_s2;
	assign mem_wdata = clearing_q ? '0 : new_s2;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_q <= mem[idx_s1];
		end
	end

	// Last write, for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q <= 1'b0;
		end else if (clearing_q) begin
			fwd_en_q <= 1'b0;
		end else if (adv) begin
			fwd_en_q <= wr_item_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= new_s2;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			cell_value_q <= hit_s2 ? new_s2 : '0;
			hit_q        <= hit_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign hit        = hit_q;

endmodule

/* bench/downsampled_max_response_map_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own copy of the
// max map and compares every result beat against the oldest prediction.
module downsampled_max_response_map_checker #(
	parameter int DOWNSAMPLE     = 4,
	parameter int MAX_MAP_WIDTH  = 256,
	parameter int MAX_MAP_HEIGHT = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dmrm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dmrm_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  mode,
	input  logic [dmrm_pkg::POS_W-1:0]            pos_x,
	input  logic [dmrm_pkg::POS_W-1:0]            pos_y,
	input  logic signed [dmrm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [dmrm_pkg::VAL_W-1:0]            cell_value,
	input  logic                                  hit,
	output int                                    mismatches,
	output int                                    outstanding,
	output int                                    results_seen
);

	typedef struct packed {
		dmrm_pkg::cell_val_t value;
		logic                hit;
	} cell_result_t;

	cell_result_t        pending_results[$];
	// sparse copy of the map; a missing entry reads as zero
	dmrm_pkg::cell_val_t peak_cells[int];
	int                  image_w = dmrm_pkg::IMAGE_SIZE_RST;
	int                  image_h = dmrm_pkg::IMAGE_SIZE_RST;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
	end

	// cells along one axis: ceil(pixels / DOWNSAMPLE), at least 1, at most limit
	function automatic int cells_along(int pixels, int limit);
		int n;
		n = (pixels + DOWNSAMPLE - 1) / DOWNSAMPLE;
		if (n < 1)
			n = 1;
		if (n > limit)
			n = limit;
		return n;
	endfunction

	// apply one input beat to the map copy and return the result it gives
	function automatic cell_result_t apply_beat(logic m, int px, int py,
			dmrm_pkg::sample_t s);
		int                  span_x;
		int                  span_y;
		int                  cx;
		int                  cy;
		int                  addr;
		dmrm_pkg::cell_val_t cur;
		cell_result_t        r;
		span_x = cells_along(image_w, MAX_MAP_WIDTH);
		span_y = cells_along(image_h, MAX_MAP_HEIGHT);
		cx     = px / DOWNSAMPLE;
		cy     = py / DOWNSAMPLE;
		r      = '0;
		if (cx >= span_x || cy >= span_y)
			return r;
		addr = cy * span_x + cx;
		cur  = peak_cells.exists(addr) ? peak_cells[addr] : '0;
		// negative samples never beat the zero floor
		if (m == dmrm_pkg::MODE_MERGE && !s[dmrm_pkg::SAMPLE_W-1] &&
				s[dmrm_pkg::VAL_W-1:0] > cur) begin
			cur              = s[dmrm_pkg::VAL_W-1:0];
			peak_cells[addr] = cur;
		end
		r.value = cur;
		r.hit   = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cell_result_t oldest;
		if (!arst_n) begin
			image_w = dmrm_pkg::IMAGE_SIZE_RST;
			image_h = dmrm_pkg::IMAGE_SIZE_RST;
			peak_cells.delete();
			pending_results.delete();
			outstanding = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: cell_value %0h hit %0b",
						cell_value, hit);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					results_seen++;
					if (cell_value !== oldest.value) begin
						$error("cell_value: expected %0h, actual %0h", oldest.value, cell_value);
						mismatches++;
					end
					if (hit !== oldest.hit) begin
						$error("hit: expected %0b, actual %0b", oldest.hit, hit);
						mismatches++;
					end
				end
			end
			// a register write resizes the map and wipes it
			if (cfg_we) begin
				if (cfg_index == dmrm_pkg::CFG_IMAGE_WIDTH)
					image_w = cfg_wdata;
				else if (cfg_index == dmrm_pkg::CFG_IMAGE_HEIGHT)
					image_h = cfg_wdata;
				peak_cells.delete();
			end
			if (in_valid && !in_stall)
				pending_results.push_back(apply_beat(mode, pos_x, pos_y, sample));
			outstanding = pending_results.size();
		end
	end

endmodule

/* bench/downsampled_max_response_map_tb.sv */
`timescale 1ns / 1ps

module downsampled_max_response_map_tb;

	localparam int DOWNSAMPLE     = 4;
	localparam int MAX_MAP_WIDTH  = 256;
	localparam int MAX_MAP_HEIGHT = 256;
	localparam int BEATS_PER_MIX  = 44;
	localparam int HOLD_CYCLES    = 300;
	// nine clearing sweeps of the whole store dominate the run
	localparam int LIMIT_CYCLES   = 3000000;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic [dmrm_pkg::CFG_IDX_W-1:0]        cfg_index;
	logic [dmrm_pkg::CFG_W-1:0]            cfg_wdata;
	logic                                  in_valid;
	logic                                  in_stall;
	logic                                  mode;
	logic [dmrm_pkg::POS_W-1:0]            pos_x;
	logic [dmrm_pkg::POS_W-1:0]            pos_y;
	logic signed [dmrm_pkg::SAMPLE_W-1:0]  sample;
	logic                                  out_valid;
	logic                                  out_stall;
	logic [dmrm_pkg::VAL_W-1:0]            cell_value;
	logic                                  hit;

	int mismatches;
	int outstanding;
	int results_seen;
	int send_idle_pct;
	int stall_pct;
	int holds_asked;
	int beats_sent;
	int geometries;
	int img_w;
	int img_h;
	int cycle_count;

	always #5 clk = ~clk;

	downsampled_max_response_map #(
		.DOWNSAMPLE     (DOWNSAMPLE),
		.MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
		.MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value),
		.hit        (hit)
	);

	downsampled_max_response_map_checker #(
		.DOWNSAMPLE     (DOWNSAMPLE),
		.MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
		.MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_value   (cell_value),
		.hit          (hit),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("downsampled_max_response_map_tb: done, errors");
		$finish;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin : result_sink
		int holds_done;
		holds_done = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// map size along one axis, used only to aim positions
	function automatic int span_of(int pixels, int limit);
		int n;
		n = (pixels + DOWNSAMPLE - 1) / DOWNSAMPLE;
		return (n < 1) ? 1 : (n > limit) ? limit : n;
	endfunction

	// one input beat; entered and left at a falling edge, valid left high
	task automatic send_beat(logic m, int px, int py, logic [dmrm_pkg::SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode     <= m;
		pos_x    <= px[dmrm_pkg::POS_W-1:0];
		pos_y    <= py[dmrm_pkg::POS_W-1:0];
		sample   <= s;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		beats_sent++;
	endtask

	// random beat, mostly aimed at cells inside the current map
	task automatic send_random_beat();
		int   span_x;
		int   span_y;
		int   cx;
		int   cy;
		int   pick;
		logic m;
		logic [dmrm_pkg::SAMPLE_W-1:0] s;
		span_x = span_of(img_w, MAX_MAP_WIDTH);
		span_y = span_of(img_h, MAX_MAP_HEIGHT);
		m      = ($urandom_range(99) < 35) ? dmrm_pkg::MODE_QUERY : dmrm_pkg::MODE_MERGE;
		s      = ($urandom_range(99) < 25) ? dmrm_pkg::SAMPLE_W'($urandom_range(65535))
			: dmrm_pkg::SAMPLE_W'($urandom_range(32767));
		pick   = $urandom_range(99);
		if (pick < 15) begin
			// anywhere in the position range
			send_beat(m, $urandom_range(4095), $urandom_range(4095), s);
		end else begin
			if (pick < 55) begin
				// a few hot cells so merges pile up on the same address
				cx = $urandom_range((span_x < 3 ? span_x : 3) - 1);
				cy = $urandom_range((span_y < 3 ? span_y : 3) - 1);
			end else if (pick < 65) begin
				// last cell or one past it
				cx = span_x - $urandom_range(1);
				cy = span_y - $urandom_range(1);
			end else begin
				cx = $urandom_range(span_x - 1);
				cy = $urandom_range(span_y - 1);
			end
			send_beat(m, cx * DOWNSAMPLE + $urandom_range(DOWNSAMPLE - 1),
				cy * DOWNSAMPLE + $urandom_range(DOWNSAMPLE - 1), s);
		end
	endtask

	// drop valid and wait out every expected result
	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, then wait for the clearing sweep to finish
	task automatic write_reg(logic [dmrm_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_index <= idx;
		cfg_wdata <= value[dmrm_pkg::CFG_W-1:0];
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == dmrm_pkg::CFG_IMAGE_WIDTH)
			img_w = value;
		else
			img_h = value;
		while (!in_stall)
			@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random beats under each idling mix; optional long hold-off in the first
	task automatic random_phase(bit with_hold);
		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			if (with_hold && mix == 0)
				holds_asked++;
			repeat (BEATS_PER_MIX) send_random_beat();
		end
		settle();
		geometries++;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = dmrm_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		mode          = dmrm_pkg::MODE_MERGE;
		pos_x         = '0;
		pos_y         = '0;
		sample        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		holds_asked   = 0;
		beats_sent    = 0;
		geometries    = 0;
		img_w         = dmrm_pkg::IMAGE_SIZE_RST;
		img_h         = dmrm_pkg::IMAGE_SIZE_RST;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed beats on the reset-size map (256 x 256 cells)
		send_beat(dmrm_pkg::MODE_MERGE, 0, 0, 16'h7FFF);      // largest sample
		send_beat(dmrm_pkg::MODE_MERGE, 1, 2, 16'h0001);      // smaller, same cell
		send_beat(dmrm_pkg::MODE_QUERY, 3, 3, 16'h8000);      // query ignores sample
		send_beat(dmrm_pkg::MODE_MERGE, 4, 0, 16'h8000);      // most negative sample
		send_beat(dmrm_pkg::MODE_MERGE, 5, 1, 16'hFFFF);      // -1 stays below zero
		send_beat(dmrm_pkg::MODE_MERGE, 6, 2, 16'h1234);
		send_beat(dmrm_pkg::MODE_MERGE, 8, 8, 16'h0100);      // back-to-back on one cell
		send_beat(dmrm_pkg::MODE_MERGE, 9, 9, 16'h0200);
		send_beat(dmrm_pkg::MODE_MERGE, 10, 10, 16'h0150);
		send_beat(dmrm_pkg::MODE_QUERY, 11, 11, 16'h0000);
		send_beat(dmrm_pkg::MODE_QUERY, 1023, 1023, 16'h7FFF); // last cell, never written
		send_beat(dmrm_pkg::MODE_MERGE, 1020, 1021, 16'h7FFE);
		send_beat(dmrm_pkg::MODE_QUERY, 1022, 1020, 16'h0000);
		send_beat(dmrm_pkg::MODE_MERGE, 1024, 0, 16'h7FFF);    // just right of the map
		send_beat(dmrm_pkg::MODE_QUERY, 0, 1024, 16'h0000);    // just below the map
		send_beat(dmrm_pkg::MODE_MERGE, 4095, 4095, 16'h7FFF); // far corner of positions
		send_beat(dmrm_pkg::MODE_QUERY, 4095, 0, 16'hFFFF);
		send_beat(dmrm_pkg::MODE_MERGE, 2730, 1365, 16'h5555);
		settle();

		random_phase(1'b1);
		write_reg(dmrm_pkg::CFG_IMAGE_WIDTH, 0);        // zero width: one column
		random_phase(1'b0);
		write_reg(dmrm_pkg::CFG_IMAGE_HEIGHT, 0);       // single cell
		random_phase(1'b0);
		write_reg(dmrm_pkg::CFG_IMAGE_WIDTH, 2047);     // width saturates
		write_reg(dmrm_pkg::CFG_IMAGE_HEIGHT, 37);
		random_phase(1'b0);
		write_reg(dmrm_pkg::CFG_IMAGE_WIDTH, 13);
		write_reg(dmrm_pkg::CFG_IMAGE_HEIGHT, 2047);    // height saturates
		random_phase(1'b0);
		write_reg(dmrm_pkg::CFG_IMAGE_WIDTH, 1023);
		write_reg(dmrm_pkg::CFG_IMAGE_HEIGHT, 3);
		random_phase(1'b0);
		repeat (10) @(negedge clk);

		$display("Sent %0d input beats over %0d map sizes; %0d results checked.",
			beats_sent, geometries, results_seen);
		$display("Mixes of sender gaps and receiver stalls, one %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0 && outstanding == 0)
			$display("downsampled_max_response_map_tb: done, clean");
		else
			$display("downsampled_max_response_map_tb: done, errors");
		$finish;
	end

endmodule
